[hw/rtl/delta_list_sleep_queue_core_assert.svh]
// Assertion macros for the delta-list sleep queue port checker.
// Both expect clk_i and rst_ni in the scope that uses them.
`ifndef DELTA_LIST_SLEEP_QUEUE_CORE_ASSERT_SVH
`define DELTA_LIST_SLEEP_QUEUE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLSQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dlsq: port check failed");

// Consequent must hold in the cycle after the antecedent.
`define DLSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlsq: port check failed");

`endif

[hw/rtl/dlsq_pkg.sv]
// Shared codes, field widths and controller/datapath link types for the sleep queue.
// No dependencies.
`default_nettype none

package dlsq_pkg;

  // Fixed field widths of the channels
  localparam int OP_W   = 2;
  localparam int TID_W  = 8;
  localparam int TICK_W = 16;
  localparam int STS_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Reply status codes
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STS_W-1:0] STS_ZERO      = 2'd2;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd3;

  // Result kinds
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Read address base
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_CUR,
    RD_NEXT
  } dlsq_rd_e;

  // Walk index update
  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC
  } dlsq_idx_e;

  // Entry write source and address
  typedef enum logic [2:0] {
    W_NEW_ZERO,
    W_PLACE,
    W_APPEND,
    W_CARRY,
    W_SHIFT,
    W_HEAD,
    W_COMPACT
  } dlsq_wr_e;

  // Entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_SUB_N
  } dlsq_cnt_e;

  // Release count update
  typedef enum logic [1:0] {
    N_HOLD,
    N_LD_IDX,
    N_LD_CNT
  } dlsq_n_e;

  typedef struct packed {
    logic             ld_item;
    dlsq_rd_e         rd_sel;
    logic             rd_off;
    dlsq_idx_e        idx_op;
    logic             we;
    dlsq_wr_e         wr_sel;
    logic             t_sub;
    logic             add_ld;
    dlsq_cnt_e        cnt_op;
    dlsq_n_e          n_op;
    logic             out_ld;
    logic             out_kind;
    logic [STS_W-1:0] out_status;
    logic             out_last;
  } dlsq_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            t_zero;
    logic            cnt_zero;
    logic            full;
    logic            last_idx;
    logic            idx_eq_cnt;
    logic            ins_place;
    logic            id_match;
    logic            head_due;
    logic            d_zero;
    logic            emit_last;
    logic            compact_last;
    logic            n_all;
    logic            slot_free;
  } dlsq_stat_t;

endpackage

`default_nettype wire

[hw/rtl/dlsq_in_if.sv]
// Request channel of the sleep queue: valid/ready plus operation, thread id and ticks.
// Depends on dlsq_pkg.
`default_nettype none

interface dlsq_in_if;
  logic                         valid;
  logic                         ready;
  logic [dlsq_pkg::OP_W-1:0]    operation;
  logic [dlsq_pkg::TID_W-1:0]   thread_id;
  logic [dlsq_pkg::TICK_W-1:0]  sleep_ticks;

  modport source (output valid, output operation, output thread_id, output sleep_ticks,
                  input ready);
  modport sink (input valid, input operation, input thread_id, input sleep_ticks,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/dlsq_out_if.sv]
// Result channel of the sleep queue: valid/ready plus kind, status, released id and last.
// Depends on dlsq_pkg.
`default_nettype none

interface dlsq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [dlsq_pkg::STS_W-1:0]  status;
  logic [dlsq_pkg::TID_W-1:0]  released_id;
  logic                        last;

  modport source (output valid, output kind, output status, output released_id,
                  output last, input ready);
  modport sink (input valid, input kind, input status, input released_id, input last,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/dlsq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dlsq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/dlsq_datapath.sv]
// Sleep queue datapath: entry RAM, walk index, remaining ticks, carry and result register.
// Depends on dlsq_pkg, dlsq_out_if and dlsq_ram.
`default_nettype none

module dlsq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int TICK_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dlsq_pkg::OP_W-1:0]     in_operation_i,
  input  logic [dlsq_pkg::TID_W-1:0]    in_thread_id_i,
  input  logic [dlsq_pkg::TICK_W-1:0]   in_sleep_ticks_i,
  input  dlsq_pkg::dlsq_cmd_t           cmd_i,
  output dlsq_pkg::dlsq_stat_t          stat_o,
  dlsq_out_if.source                    out_o
);

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W   = ID_BITS + TICK_BITS;
  localparam int OutIdW  = dlsq_pkg::TID_W;

  logic [dlsq_pkg::OP_W-1:0]  op_q;
  logic [ID_BITS-1:0]         id_q;
  logic [TICK_BITS-1:0]       t_q;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [ADDR_W-1:0]          idx_q;
  logic [CNT_W-1:0]           n_q;
  logic [ENT_W-1:0]           carry_q;
  logic [TICK_BITS-1:0]       add_q;
  logic                       out_valid_q, out_valid_d;
  logic                       out_kind_q;
  logic [dlsq_pkg::STS_W-1:0] out_status_q;
  logic [OutIdW-1:0]          out_id_q;
  logic                       out_last_q;

  logic [ENT_W-1:0]     rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic [TICK_BITS-1:0] rd_delta;
  logic [CNT_W-1:0]     idx_ext, idx_inc;
  logic [CNT_W-1:0]     rd_base;
  logic [CNT_W:0]       rd_sum;
  logic [ADDR_W-1:0]    raddr, waddr;
  logic [ENT_W-1:0]     wdata;
  logic                 slot_free;

  assign rd_id    = rdata[ENT_W-1:TICK_BITS];
  assign rd_delta = rdata[TICK_BITS-1:0];
  assign idx_ext  = CNT_W'(idx_q);
  assign idx_inc  = idx_ext + CNT_W'(1);

  // Read address: base plus optional release count for compaction
  always_comb begin
    case (cmd_i.rd_sel)
      dlsq_pkg::RD_CUR:  rd_base = idx_ext;
      dlsq_pkg::RD_NEXT: rd_base = idx_inc;
      default:           rd_base = '0;
    endcase
    rd_sum = {1'b0, rd_base} + (cmd_i.rd_off ? {1'b0, n_q} : '0);
    raddr  = rd_sum[ADDR_W-1:0];
  end

  always_comb begin
    case (cmd_i.wr_sel)
      dlsq_pkg::W_PLACE: begin
        waddr = idx_q;
        wdata = {id_q, t_q};
      end
      dlsq_pkg::W_APPEND: begin
        waddr = cnt_q[ADDR_W-1:0];
        wdata = {id_q, t_q - rd_delta};
      end
      dlsq_pkg::W_CARRY: begin
        waddr = idx_q;
        wdata = carry_q;
      end
      dlsq_pkg::W_SHIFT: begin
        waddr = idx_q - ADDR_W'(1);
        wdata = {rd_id, rd_delta + add_q};
      end
      dlsq_pkg::W_HEAD: begin
        waddr = '0;
        wdata = {rd_id, rd_delta - TICK_BITS'(1)};
      end
      dlsq_pkg::W_COMPACT: begin
        waddr = idx_q;
        wdata = rdata;
      end
      default: begin
        waddr = '0;
        wdata = {id_q, t_q};
      end
    endcase
  end

  dlsq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    case (cmd_i.cnt_op)
      dlsq_pkg::CNT_INC:   cnt_d = cnt_q + CNT_W'(1);
      dlsq_pkg::CNT_DEC:   cnt_d = cnt_q - CNT_W'(1);
      dlsq_pkg::CNT_SUB_N: cnt_d = cnt_q - n_q;
      default:             cnt_d = cnt_q;
    endcase
    if (cmd_i.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      op_q <= in_operation_i;
      id_q <= ID_BITS'(in_thread_id_i);
      t_q  <= TICK_BITS'(in_sleep_ticks_i);
    end else if (cmd_i.t_sub) begin
      t_q <= t_q - rd_delta;
    end

    case (cmd_i.idx_op)
      dlsq_pkg::IDX_ZERO: idx_q <= '0;
      dlsq_pkg::IDX_INC:  idx_q <= idx_q + ADDR_W'(1);
      default:            idx_q <= idx_q;
    endcase

    case (cmd_i.n_op)
      dlsq_pkg::N_LD_IDX: n_q <= idx_ext;
      dlsq_pkg::N_LD_CNT: n_q <= cnt_q;
      default:            n_q <= n_q;
    endcase

    // Displaced entry rides ahead during an insert
    if (cmd_i.we && cmd_i.wr_sel == dlsq_pkg::W_PLACE) begin
      carry_q <= {rd_id, rd_delta - t_q};
    end else if (cmd_i.we && cmd_i.wr_sel == dlsq_pkg::W_CARRY) begin
      carry_q <= rdata;
    end

    // Removed delta folds into the following entry once
    if (cmd_i.add_ld) begin
      add_q <= rd_delta;
    end else if (cmd_i.we && cmd_i.wr_sel == dlsq_pkg::W_SHIFT) begin
      add_q <= '0;
    end

    if (cmd_i.out_ld) begin
      out_kind_q   <= cmd_i.out_kind;
      out_status_q <= cmd_i.out_status;
      out_id_q     <= (cmd_i.out_kind == dlsq_pkg::KIND_RELEASE) ? OutIdW'(rd_id) : '0;
      out_last_q   <= cmd_i.out_last;
    end
  end

  always_comb begin
    stat_o.op           = op_q;
    stat_o.t_zero       = (t_q == '0);
    stat_o.cnt_zero     = (cnt_q == '0);
    stat_o.full         = (cnt_q == CNT_W'(QUEUE_DEPTH));
    stat_o.last_idx     = (idx_inc == cnt_q);
    stat_o.idx_eq_cnt   = (idx_ext == cnt_q);
    stat_o.ins_place    = (idx_q == '0) ? (t_q <= rd_delta) : (t_q < rd_delta);
    stat_o.id_match     = (rd_id == id_q);
    stat_o.head_due     = (rd_delta <= TICK_BITS'(1));
    stat_o.d_zero       = (rd_delta == '0);
    stat_o.emit_last    = (idx_inc == n_q);
    stat_o.compact_last = (({1'b0, idx_inc} + {1'b0, n_q}) == {1'b0, cnt_q});
    stat_o.n_all        = (n_q == cnt_q);
    stat_o.slot_free    = slot_free;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.status      = out_status_q;
  assign out_o.released_id = out_id_q;
  assign out_o.last        = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/dlsq_ctrl.sv]
// Sleep queue controller: sequences insert, remove and tick walks over the entry RAM.
// Depends on dlsq_pkg.
`default_nettype none

module dlsq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dlsq_pkg::dlsq_stat_t stat_i,
  output dlsq_pkg::dlsq_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_INS_WALK   = 4'd2;
  localparam logic [3:0] S_INS_SHIFT  = 4'd3;
  localparam logic [3:0] S_RM_FIND    = 4'd4;
  localparam logic [3:0] S_RM_SHIFT   = 4'd5;
  localparam logic [3:0] S_TK_HEAD    = 4'd6;
  localparam logic [3:0] S_TK_SCAN    = 4'd7;
  localparam logic [3:0] S_TK_EMIT    = 4'd8;
  localparam logic [3:0] S_TK_COMPACT = 4'd9;
  localparam logic [3:0] S_REPLY      = 4'd10;

  logic [3:0]                 state_q, state_d;
  logic [dlsq_pkg::STS_W-1:0] reply_q, reply_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    reply_d = reply_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d       = S_DECODE;
        end
      end

      S_DECODE: begin
        // Prime the read of the head entry
        cmd_o.rd_sel = dlsq_pkg::RD_ZERO;
        cmd_o.idx_op = dlsq_pkg::IDX_ZERO;
        case (stat_i.op)
          dlsq_pkg::OP_INSERT: begin
            if (stat_i.t_zero) begin
              reply_d = dlsq_pkg::STS_ZERO;
              state_d = S_REPLY;
            end else if (stat_i.full) begin
              reply_d = dlsq_pkg::STS_FULL;
              state_d = S_REPLY;
            end else if (stat_i.cnt_zero) begin
              cmd_o.we     = 1'b1;
              cmd_o.wr_sel = dlsq_pkg::W_NEW_ZERO;
              cmd_o.cnt_op = dlsq_pkg::CNT_INC;
              reply_d      = dlsq_pkg::STS_OK;
              state_d      = S_REPLY;
            end else begin
              state_d = S_INS_WALK;
            end
          end
          dlsq_pkg::OP_REMOVE: begin
            if (stat_i.cnt_zero) begin
              reply_d = dlsq_pkg::STS_NOT_FOUND;
              state_d = S_REPLY;
            end else begin
              state_d = S_RM_FIND;
            end
          end
          dlsq_pkg::OP_TICK: begin
            state_d = stat_i.cnt_zero ? S_IDLE : S_TK_HEAD;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_INS_WALK: begin
        if (stat_i.ins_place) begin
          cmd_o.we     = 1'b1;
          cmd_o.wr_sel = dlsq_pkg::W_PLACE;
          cmd_o.idx_op = dlsq_pkg::IDX_INC;
          cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
          state_d      = S_INS_SHIFT;
        end else if (stat_i.last_idx) begin
          cmd_o.we     = 1'b1;
          cmd_o.wr_sel = dlsq_pkg::W_APPEND;
          cmd_o.cnt_op = dlsq_pkg::CNT_INC;
          reply_d      = dlsq_pkg::STS_OK;
          state_d      = S_REPLY;
        end else begin
          cmd_o.t_sub  = 1'b1;
          cmd_o.idx_op = dlsq_pkg::IDX_INC;
          cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
        end
      end

      S_INS_SHIFT: begin
        cmd_o.we     = 1'b1;
        cmd_o.wr_sel = dlsq_pkg::W_CARRY;
        if (stat_i.idx_eq_cnt) begin
          cmd_o.cnt_op = dlsq_pkg::CNT_INC;
          reply_d      = dlsq_pkg::STS_OK;
          state_d      = S_REPLY;
        end else begin
          cmd_o.idx_op = dlsq_pkg::IDX_INC;
          cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
        end
      end

      S_RM_FIND: begin
        if (stat_i.id_match) begin
          if (stat_i.last_idx) begin
            cmd_o.cnt_op = dlsq_pkg::CNT_DEC;
            reply_d      = dlsq_pkg::STS_OK;
            state_d      = S_REPLY;
          end else begin
            cmd_o.add_ld = 1'b1;
            cmd_o.idx_op = dlsq_pkg::IDX_INC;
            cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
            state_d      = S_RM_SHIFT;
          end
        end else if (stat_i.last_idx) begin
          reply_d = dlsq_pkg::STS_NOT_FOUND;
          state_d = S_REPLY;
        end else begin
          cmd_o.idx_op = dlsq_pkg::IDX_INC;
          cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
        end
      end

      S_RM_SHIFT: begin
        cmd_o.we     = 1'b1;
        cmd_o.wr_sel = dlsq_pkg::W_SHIFT;
        if (stat_i.last_idx) begin
          cmd_o.cnt_op = dlsq_pkg::CNT_DEC;
          reply_d      = dlsq_pkg::STS_OK;
          state_d      = S_REPLY;
        end else begin
          cmd_o.idx_op = dlsq_pkg::IDX_INC;
          cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
        end
      end

      S_TK_HEAD: begin
        if (!stat_i.head_due) begin
          cmd_o.we     = 1'b1;
          cmd_o.wr_sel = dlsq_pkg::W_HEAD;
          state_d      = S_IDLE;
        end else if (stat_i.last_idx) begin
          cmd_o.n_op   = dlsq_pkg::N_LD_CNT;
          cmd_o.idx_op = dlsq_pkg::IDX_ZERO;
          cmd_o.rd_sel = dlsq_pkg::RD_ZERO;
          state_d      = S_TK_EMIT;
        end else begin
          cmd_o.idx_op = dlsq_pkg::IDX_INC;
          cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
          state_d      = S_TK_SCAN;
        end
      end

      S_TK_SCAN: begin
        if (!stat_i.d_zero || stat_i.last_idx) begin
          cmd_o.n_op   = stat_i.d_zero ? dlsq_pkg::N_LD_CNT : dlsq_pkg::N_LD_IDX;
          cmd_o.idx_op = dlsq_pkg::IDX_ZERO;
          cmd_o.rd_sel = dlsq_pkg::RD_ZERO;
          state_d      = S_TK_EMIT;
        end else begin
          cmd_o.idx_op = dlsq_pkg::IDX_INC;
          cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
        end
      end

      S_TK_EMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.out_ld     = 1'b1;
          cmd_o.out_kind   = dlsq_pkg::KIND_RELEASE;
          cmd_o.out_status = dlsq_pkg::STS_OK;
          cmd_o.out_last   = stat_i.emit_last;
          if (stat_i.emit_last) begin
            if (stat_i.n_all) begin
              cmd_o.cnt_op = dlsq_pkg::CNT_SUB_N;
              state_d      = S_IDLE;
            end else begin
              cmd_o.idx_op = dlsq_pkg::IDX_ZERO;
              cmd_o.rd_sel = dlsq_pkg::RD_ZERO;
              cmd_o.rd_off = 1'b1;
              state_d      = S_TK_COMPACT;
            end
          end else begin
            cmd_o.idx_op = dlsq_pkg::IDX_INC;
            cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
          end
        end else begin
          // Hold the current entry on the read port
          cmd_o.rd_sel = dlsq_pkg::RD_CUR;
        end
      end

      S_TK_COMPACT: begin
        cmd_o.we     = 1'b1;
        cmd_o.wr_sel = dlsq_pkg::W_COMPACT;
        cmd_o.rd_off = 1'b1;
        if (stat_i.compact_last) begin
          cmd_o.cnt_op = dlsq_pkg::CNT_SUB_N;
          state_d      = S_IDLE;
        end else begin
          cmd_o.idx_op = dlsq_pkg::IDX_INC;
          cmd_o.rd_sel = dlsq_pkg::RD_NEXT;
        end
      end

      S_REPLY: begin
        if (stat_i.slot_free) begin
          cmd_o.out_ld     = 1'b1;
          cmd_o.out_kind   = dlsq_pkg::KIND_STATUS;
          cmd_o.out_status = reply_q;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reply_q <= reply_d;
  end

endmodule

`default_nettype wire

[hw/rtl/delta_list_sleep_queue_core.sv]
// Delta-list sleep queue: one transaction at a time, walked one entry per cycle over one RAM
// unless a release waits on a stalled result. Insert or remove walks the entries at most once.
// Tick: scan the due entries, release n entries, compact the rest.
// Throughput is one transaction per walk; the single RAM read port sets the pace.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending result.
`default_nettype none

module delta_list_sleep_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int TICK_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlsq_in_if.sink    in_i,
  dlsq_out_if.source out_o
);

  // Controller issues one command word per cycle; the datapath answers
  // with compare results on the entry currently on the RAM read port.
  dlsq_pkg::dlsq_cmd_t  cmd;
  dlsq_pkg::dlsq_stat_t stat;
  logic                 in_ready;

  // Accept a request only in idle; the result register decouples the
  // output side, so a finished result may wait while the next one runs.
  assign in_i.ready = in_ready;

  dlsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Entries sit in wake order in the RAM, each holding an id and the tick
  // difference to the entry before it. Inserts ripple the displaced entry
  // forward and removes shift the tail back in one pass; ticks compact it after releasing.
  dlsq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .TICK_BITS   (TICK_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_operation_i   (in_i.operation),
    .in_thread_id_i   (in_i.thread_id),
    .in_sleep_ticks_i (in_i.sleep_ticks),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_o            (out_o)
  );

endmodule

`default_nettype wire

[hw/rtl/dlsq_checker.sv]
// Port-level checker for the sleep queue, bound to the top level.
// Depends on dlsq_pkg and delta_list_sleep_queue_core_assert.svh.
`default_nettype none

`include "delta_list_sleep_queue_core_assert.svh"

module dlsq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_kind_i,
  input logic [dlsq_pkg::STS_W-1:0]  out_status_i,
  input logic [dlsq_pkg::TID_W-1:0]  out_released_id_i,
  input logic                        out_last_i
);

  // A stalled result stays offered
  `DLSQ_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // Only one transaction in flight
  `DLSQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // Status replies close their transaction and carry no id
  `DLSQ_ASSERT_NOW(a_reply_last, out_valid_i && out_kind_i == dlsq_pkg::KIND_STATUS,
                   out_last_i)
  `DLSQ_ASSERT_NOW(a_reply_no_id, out_valid_i && out_kind_i == dlsq_pkg::KIND_STATUS,
                   out_released_id_i == '0)

  // Releases always report ok
  `DLSQ_ASSERT_NOW(a_release_ok, out_valid_i && out_kind_i == dlsq_pkg::KIND_RELEASE,
                   out_status_i == dlsq_pkg::STS_OK)

endmodule

bind delta_list_sleep_queue_core dlsq_checker u_dlsq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_kind_i        (out_o.kind),
  .out_status_i      (out_o.status),
  .out_released_id_i (out_o.released_id),
  .out_last_i        (out_o.last)
);

`default_nettype wire

[tb/delta_list_sleep_queue_core_tb.sv]
// Testbench for delta_list_sleep_queue_core: random and directed insert, remove and tick
// transactions, with results checked against a delta-list predictor kept in this module.
// Depends on dlsq_pkg, dlsq_in_if, dlsq_out_if and the core RTL.
`timescale 1ns / 100ps

module delta_list_sleep_queue_core_tb;

  localparam int unsigned QDEPTH         = 16;
  localparam int unsigned ID_W           = 8;
  localparam int unsigned TICK_W         = 16;
  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned RANDOM_ITEMS   = 285;
  localparam int unsigned BACKLOG_MAX    = 4;
  localparam int unsigned HOLDOFF_AT     = 60;
  localparam int unsigned HOLDOFF_CYCLES = 250;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // Operation 3 has no meaning for the block; it must be dropped silently.
  localparam logic [dlsq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [dlsq_pkg::OP_W-1:0]  op;
    logic [dlsq_pkg::TID_W-1:0] thread_id;
    logic [TICK_W-1:0]          sleep_ticks;
  } sleep_req_t;

  typedef struct packed {
    logic                       kind;
    logic [dlsq_pkg::STS_W-1:0] status;
    logic [dlsq_pkg::TID_W-1:0] released_id;
    logic                       last;
  } sched_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dlsq_in_if  in_ch ();
  dlsq_out_if out_ch ();

  delta_list_sleep_queue_core #(
    .QUEUE_DEPTH (QDEPTH),
    .ID_BITS     (ID_W),
    .TICK_BITS   (TICK_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Predictor state: sleepers in wake order, each with its tick delta to the one before.
  logic [dlsq_pkg::TID_W-1:0] sleeper_thread [QDEPTH];
  logic [TICK_W-1:0]          sleeper_delta  [QDEPTH];
  int unsigned                sleeper_count = 0;

  // Replies and wakeups still owed by the block, and requests not yet driven, oldest first.
  sched_reply_t sched_replies [$];
  sleep_req_t   request_backlog [$];

  int unsigned requests_issued   = 0;
  int unsigned requests_accepted = 0;
  int unsigned replies_checked   = 0;
  int unsigned fail_count        = 0;
  int unsigned status_seen [4]   = '{0, 0, 0, 0};
  int unsigned wakeups_seen      = 0;
  int unsigned ignored_seen      = 0;
  int unsigned peak_depth        = 0;
  int unsigned idle_cycles       = 0;

  bit          request_taken = 1'b0;
  int unsigned send_gap      = 0;
  bit          send_burst    = 1'b0;
  int unsigned recv_stall    = 0;
  bit          recv_burst    = 1'b0;
  int unsigned holdoff_left  = 0;
  bit          holdoff_done  = 1'b0;
  sleep_req_t  next_req;

  // Most gaps are short; a few are long. Burst mode removes them entirely.
  function automatic int unsigned pick_gap(bit burst, int unsigned quiet_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (burst || r < quiet_pct) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Splice a sleeper in: walk the list, consume the deltas passed, and shorten the
  // delta of the entry it lands in front of. A tie with the head goes first; a tie
  // anywhere else goes behind the equal entries.
  function automatic logic [dlsq_pkg::STS_W-1:0] sleep_insert(
      logic [dlsq_pkg::TID_W-1:0] id, logic [TICK_W-1:0] ticks);
    int unsigned t, pos, i;
    t = ticks;
    if (t == 0) return dlsq_pkg::STS_ZERO;
    if (sleeper_count >= QDEPTH) return dlsq_pkg::STS_FULL;
    if (sleeper_count == 0) begin
      pos = 0;
    end else if (t <= sleeper_delta[0]) begin
      sleeper_delta[0] = TICK_W'(sleeper_delta[0] - t);
      pos = 0;
    end else begin
      i = 0;
      while (i + 1 < sleeper_count && t >= sleeper_delta[i]) begin
        t -= sleeper_delta[i];
        i++;
      end
      if (i + 1 == sleeper_count && t >= sleeper_delta[i]) begin
        t -= sleeper_delta[i];
        pos = sleeper_count;
      end else begin
        sleeper_delta[i] = TICK_W'(sleeper_delta[i] - t);
        pos = i;
      end
    end
    for (i = sleeper_count; i > pos; i--) begin
      sleeper_thread[i] = sleeper_thread[i-1];
      sleeper_delta[i]  = sleeper_delta[i-1];
    end
    sleeper_thread[pos] = id;
    sleeper_delta[pos]  = TICK_W'(t);
    sleeper_count++;
    return dlsq_pkg::STS_OK;
  endfunction

  // Drop the first sleeper with this id and hand its delta to the one behind it.
  function automatic logic [dlsq_pkg::STS_W-1:0] sleep_remove(logic [dlsq_pkg::TID_W-1:0] id);
    int unsigned i, j;
    for (i = 0; i < sleeper_count; i++) begin
      if (sleeper_thread[i] == id) break;
    end
    if (i >= sleeper_count) return dlsq_pkg::STS_NOT_FOUND;
    if (i + 1 < sleeper_count) sleeper_delta[i+1] = sleeper_delta[i+1] + sleeper_delta[i];
    for (j = i; j + 1 < sleeper_count; j++) begin
      sleeper_thread[j] = sleeper_thread[j+1];
      sleeper_delta[j]  = sleeper_delta[j+1];
    end
    sleeper_count--;
    return dlsq_pkg::STS_OK;
  endfunction

  function automatic void push_status(logic [dlsq_pkg::STS_W-1:0] sts);
    sched_replies.push_back('{kind: dlsq_pkg::KIND_STATUS, status: sts, released_id: '0,
                              last: 1'b1});
    status_seen[sts]++;
  endfunction

  // Work out what one accepted transaction owes: a status reply for insert and
  // remove, one wakeup per released sleeper for a tick, nothing for operation 3.
  function automatic void schedule_request(sleep_req_t req);
    int unsigned n, i;
    case (req.op)
      dlsq_pkg::OP_INSERT: push_status(sleep_insert(req.thread_id, req.sleep_ticks));
      dlsq_pkg::OP_REMOVE: push_status(sleep_remove(req.thread_id));
      dlsq_pkg::OP_TICK: begin
        if (sleeper_count != 0) begin
          // Never decrement below zero; a zero head is simply released.
          if (sleeper_delta[0] != 0) sleeper_delta[0] = sleeper_delta[0] - 1'b1;
          n = 0;
          while (n < sleeper_count && sleeper_delta[n] == 0) n++;
          for (i = 0; i < n; i++) begin
            sched_replies.push_back('{kind: dlsq_pkg::KIND_RELEASE, status: dlsq_pkg::STS_OK,
                                      released_id: sleeper_thread[i], last: (i + 1 == n)});
          end
          for (i = 0; i + n < sleeper_count; i++) begin
            sleeper_thread[i] = sleeper_thread[i+n];
            sleeper_delta[i]  = sleeper_delta[i+n];
          end
          sleeper_count -= n;
          wakeups_seen  += n;
        end
      end
      default: ignored_seen++;
    endcase
    if (sleeper_count > peak_depth) peak_depth = sleeper_count;
  endfunction

  // Compare one result transaction with the oldest owed reply, field by field.
  function automatic void check_reply(sched_reply_t got);
    sched_reply_t want;
    if (sched_replies.size() == 0) begin
      $error("unexpected result: kind %0d status %0d released_id %0h last %0d",
             got.kind, got.status, got.released_id, got.last);
      fail_count++;
      return;
    end
    want = sched_replies.pop_front();
    replies_checked++;
    if (got.kind !== want.kind) begin
      $error("kind mismatch: expected %0d, got %0d", want.kind, got.kind);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.released_id !== want.released_id) begin
      $error("released_id mismatch: expected %0h, got %0h", want.released_id, got.released_id);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last mismatch: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endfunction

  // Queue one request for the driver, keeping the backlog short so that random
  // removes can pick ids that the predictor currently holds.
  task automatic queue_request(logic [dlsq_pkg::OP_W-1:0] op, logic [dlsq_pkg::TID_W-1:0] id,
                               logic [TICK_W-1:0] ticks);
    while (request_backlog.size() >= BACKLOG_MAX) @(posedge clk_i);
    request_backlog.push_back('{op: op, thread_id: id, sleep_ticks: ticks});
    requests_issued++;
  endtask

  // Request driver: change inputs on the falling edge; hold an offered item until taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.operation   <= dlsq_pkg::OP_INSERT;
      in_ch.thread_id   <= '0;
      in_ch.sleep_ticks <= '0;
    end else if (in_ch.valid && !request_taken) begin
      // Hold: the block has not taken the current transaction yet.
    end else if (send_gap != 0) begin
      in_ch.valid <= 1'b0;
      send_gap--;
    end else if (request_backlog.size() != 0) begin
      next_req = request_backlog.pop_front();
      in_ch.valid       <= 1'b1;
      in_ch.operation   <= next_req.op;
      in_ch.thread_id   <= next_req.thread_id;
      in_ch.sleep_ticks <= next_req.sleep_ticks;
      send_gap = pick_gap(send_burst, 55);
    end else begin
      in_ch.valid <= 1'b0;
    end
    if ($urandom_range(63) == 0) send_burst = !send_burst;
  end

  // Result receiver: random stalls, plus one long hold-off once the run is under
  // way, so the core fills up with a pending result and backs up its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_ch.ready <= 1'b0;
      holdoff_left--;
    end else if (!holdoff_done && requests_accepted >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_stall != 0) begin
      out_ch.ready <= 1'b0;
      recv_stall--;
    end else begin
      recv_stall = pick_gap(recv_burst, 75);
      out_ch.ready <= (recv_stall == 0);
      if (recv_stall != 0) recv_stall--;
    end
    if ($urandom_range(63) == 0) recv_burst = !recv_burst;
  end

  // Monitor: sample both channels on the rising edge. Check results before
  // predicting a new request; a result never belongs to a request taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        check_reply('{kind: out_ch.kind, status: out_ch.status,
                      released_id: out_ch.released_id, last: out_ch.last});
      end
      request_taken = in_ch.valid && in_ch.ready;
      if (request_taken) begin
        schedule_request('{op: in_ch.operation, thread_id: in_ch.thread_id,
                           sleep_ticks: in_ch.sleep_ticks});
        requests_accepted++;
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d replies still owed",
                 idle_cycles, sched_replies.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus: directed corner cases first, then a random mix, then drain and report.
  initial begin
    int unsigned k, r;
    logic [dlsq_pkg::TID_W-1:0] id;
    logic [TICK_W-1:0]          ticks;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Remove from an empty queue, tick an empty queue, reject a zero sleep.
    queue_request(dlsq_pkg::OP_REMOVE, 8'h3C, '0);
    queue_request(dlsq_pkg::OP_TICK, '0, '0);
    queue_request(dlsq_pkg::OP_INSERT, 8'h11, '0);
    // Extreme ids and sleeps; head ties go in front, tail ties go behind.
    queue_request(dlsq_pkg::OP_INSERT, 8'h00, 16'hFFFF);
    queue_request(dlsq_pkg::OP_INSERT, 8'hFF, 16'h0001);
    queue_request(dlsq_pkg::OP_INSERT, 8'h80, 16'h0001);
    queue_request(dlsq_pkg::OP_INSERT, 8'h7F, 16'hFFFF);
    // Duplicate id in the middle; the remove must take the first one in wake order.
    queue_request(dlsq_pkg::OP_INSERT, 8'h80, 16'h0005);
    queue_request(dlsq_pkg::OP_REMOVE, 8'h80, '0);
    queue_request(OP_UNUSED, 8'hFF, 16'hFFFF);
    queue_request(dlsq_pkg::OP_TICK, 8'hA5, 16'h5A5A);
    // Fill the queue with short, partly tied sleeps; the last insert hits a full queue.
    for (k = 0; k < 14; k++) begin
      queue_request(dlsq_pkg::OP_INSERT, ID_W'(8'h20 + k), TICK_W'((k % 5) * 2 + 1));
    end

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      r     = $urandom_range(99);
      id    = ID_W'($urandom_range(255));
      ticks = TICK_W'($urandom_range(16'hFFFF));
      if (r < 5) begin
        queue_request(OP_UNUSED, id, ticks);
      end else if (r < 45) begin
        // Small id pool now and then, to make duplicates.
        if ($urandom_range(9) < 3) id = ID_W'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 5)       ticks = '0;
        else if (r < 85) ticks = TICK_W'($urandom_range(1, 24));
        queue_request(dlsq_pkg::OP_INSERT, id, ticks);
      end else if (r < 70) begin
        // Mostly aim at an id the queue holds; otherwise expect a miss.
        if (sleeper_count != 0 && $urandom_range(3) != 0) begin
          id = sleeper_thread[$urandom_range(sleeper_count - 1)];
        end
        queue_request(dlsq_pkg::OP_REMOVE, id, ticks);
      end else begin
        queue_request(dlsq_pkg::OP_TICK, id, ticks);
      end
    end

    while (requests_accepted != requests_issued) @(posedge clk_i);
    while (sched_replies.size() != 0) @(posedge clk_i);
    // Let a trailing tick that wakes nobody finish before the final verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d ignored): %0d ok, %0d full, %0d zero-sleep,",
             requests_accepted, ignored_seen, status_seen[dlsq_pkg::STS_OK],
             status_seen[dlsq_pkg::STS_FULL], status_seen[dlsq_pkg::STS_ZERO]);
    $display("  %0d not-found replies, %0d wakeups; %0d results checked, peak depth %0d",
             status_seen[dlsq_pkg::STS_NOT_FOUND], wakeups_seen, replies_checked, peak_depth);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/dlsq_pkg.sv
hw/rtl/dlsq_in_if.sv
hw/rtl/dlsq_out_if.sv
hw/rtl/dlsq_ram.sv
hw/rtl/dlsq_datapath.sv
hw/rtl/dlsq_ctrl.sv
hw/rtl/delta_list_sleep_queue_core.sv
hw/rtl/dlsq_checker.sv
tb/delta_list_sleep_queue_core_tb.sv
